// ===== src/sts_pkg.sv =====
// Package for the SPI transfer sequencer: transaction structs and shared constants.
// No dependencies; used by every module in src.
`default_nettype none

package sts_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [BYTE_W-1:0] IDLE_BYTE = 8'hFF;
  localparam logic [TMO_W-1:0]  TMO_RESET = 16'd1000;

  // register index (byte address bit 2)
  localparam logic REG_TIMEOUT_LIMIT = 1'b0;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] select_line;
    logic [BYTE_W-1:0] length;
    logic              has_transmit;
    logic              has_receive;
    logic [BYTE_W-1:0] transmit_byte;
    logic              transmit_ready;
    logic              receive_ready;
    logic [BYTE_W-1:0] receive_byte;
  } sts_item_t;

  typedef struct packed {
    logic              select_active;
    logic [BYTE_W-1:0] select_number;
    logic              send_valid;
    logic [BYTE_W-1:0] send_data;
    logic [BYTE_W-1:0] byte_position;
    logic              store_valid;
    logic [BYTE_W-1:0] store_data;
    logic              done_valid;
    logic              done_status;
    logic              busy_res;
  } sts_result_t;

endpackage

`default_nettype wire

// ===== src/spi_transfer_sequencer_top.sv =====
// SPI transfer sequencer top level: input register, sequencer core, result register.
// A transaction on the input ports is registered in the input register, then stepped by the core,
// and its result is registered in the result register; out_stall can hold either register.
// Throughput: one transaction per cycle unless out_stall holds the output; the state step
// is a single short combinational pass between the input register and the result register.
// Reset (rst, synchronous): idle phase, timeout_limit = 1000, both channels empty.
// Depends on sts_pkg, sts_cfg_regs, sts_core.
`default_nettype none

module spi_transfer_sequencer_top
  import sts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  operation,
  input  wire logic [BYTE_W-1:0]     select_line,
  input  wire logic [BYTE_W-1:0]     length,
  input  wire logic                  has_transmit,
  input  wire logic                  has_receive,
  input  wire logic [BYTE_W-1:0]     transmit_byte,
  input  wire logic                  transmit_ready,
  input  wire logic                  receive_ready,
  input  wire logic [BYTE_W-1:0]     receive_byte,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       select_active,
  output logic      [BYTE_W-1:0]     select_number,
  output logic                       send_valid,
  output logic      [BYTE_W-1:0]     send_data,
  output logic      [BYTE_W-1:0]     byte_position,
  output logic                       store_valid,
  output logic      [BYTE_W-1:0]     store_data,
  output logic                       done_valid,
  output logic                       done_status,
  output logic                       busy_res
);

  logic [TMO_W-1:0] timeout_limit;
  logic             item_valid;
  sts_item_t        item;
  sts_item_t        item_in;
  sts_result_t      res;
  sts_result_t      res_q;
  logic             advance;
  logic             in_take;

  sts_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .timeout_limit (timeout_limit)
  );

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  assign item_in = '{
    operation:      operation,
    select_line:    select_line,
    length:         length,
    has_transmit:   has_transmit,
    has_receive:    has_receive,
    transmit_byte:  transmit_byte,
    transmit_ready: transmit_ready,
    receive_ready:  receive_ready,
    receive_byte:   receive_byte
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_take || (item_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= item_in;
    end
  end

  sts_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (item),
    .timeout_limit (timeout_limit),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign select_active = res_q.select_active;
  assign select_number = res_q.select_number;
  assign send_valid    = res_q.send_valid;
  assign send_data     = res_q.send_data;
  assign byte_position = res_q.byte_position;
  assign store_valid   = res_q.store_valid;
  assign store_data    = res_q.store_data;
  assign done_valid    = res_q.done_valid;
  assign done_status   = res_q.done_status;
  assign busy_res      = res_q.busy_res;

endmodule

`default_nettype wire

// ===== src/sts_cfg_regs.sv =====
// APB register block for the SPI transfer sequencer: holds timeout_limit.
// Depends on sts_pkg.
`default_nettype none

module sts_cfg_regs
  import sts_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [TMO_W-1:0]      timeout_limit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TMO_RESET;
    end else if (wr_en) begin
      timeout_limit <= pwdata[TMO_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TIMEOUT_LIMIT) begin
      prdata = {{(APB_DATA_W-TMO_W){1'b0}}, timeout_limit};
    end
  end

endmodule

`default_nettype wire

// ===== src/sts_core.sv =====
// Sequencer state and one-step logic: takes a registered transaction, updates
// the transfer state and forms the result. Depends on sts_pkg.
`default_nettype none

module sts_core
  import sts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire sts_item_t        item,
  input  wire logic [TMO_W-1:0] timeout_limit,
  output sts_result_t           res
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_CS_LOW   = 3'd1;
  localparam logic [2:0] PH_TRANSFER = 3'd2;
  localparam logic [2:0] PH_WAIT_TX  = 3'd3;
  localparam logic [2:0] PH_WAIT_RX  = 3'd4;
  localparam logic [2:0] PH_CS_HIGH  = 3'd5;
  localparam logic [2:0] PH_STOP     = 3'd6;

  logic [2:0]        phase, phase_next;
  logic [BYTE_W-1:0] select_reg, select_reg_next;
  logic [BYTE_W-1:0] total_bytes, total_bytes_next;
  logic [BYTE_W-1:0] current_index, current_index_next;
  logic [TMO_W-1:0]  wait_counter, wait_counter_next;
  logic              transmit_present, transmit_present_next;
  logic              receive_present, receive_present_next;

  logic [TMO_W:0]    wait_inc;
  logic              expired;
  logic [BYTE_W:0]   index_inc;

  assign wait_inc  = {1'b0, wait_counter} + {{TMO_W{1'b0}}, 1'b1};
  assign expired   = wait_inc > {1'b0, timeout_limit};
  assign index_inc = {1'b0, current_index} + {{BYTE_W{1'b0}}, 1'b1};

  always_comb begin
    phase_next            = phase;
    select_reg_next       = select_reg;
    total_bytes_next      = total_bytes;
    current_index_next    = current_index;
    wait_counter_next     = wait_counter;
    transmit_present_next = transmit_present;
    receive_present_next  = receive_present;

    res               = '0;
    res.byte_position = current_index;

    if (item.operation == OP_START) begin
      if (phase == PH_IDLE) begin
        select_reg_next       = item.select_line;
        total_bytes_next      = item.length;
        transmit_present_next = item.has_transmit;
        receive_present_next  = item.has_receive;
        current_index_next    = '0;
        wait_counter_next     = '0;
        phase_next            = PH_CS_LOW;
      end
    end else begin
      case (phase)
        PH_CS_LOW: begin
          phase_next = PH_TRANSFER;
        end
        PH_TRANSFER: begin
          res.send_valid = 1'b1;
          res.send_data  = transmit_present ? item.transmit_byte : IDLE_BYTE;
          phase_next     = PH_WAIT_TX;
        end
        PH_WAIT_TX, PH_WAIT_RX: begin
          if ((phase == PH_WAIT_TX && !item.transmit_ready) ||
              (phase == PH_WAIT_RX && !item.receive_ready)) begin
            if (expired) begin
              wait_counter_next = '0;
              phase_next        = PH_IDLE;
              res.done_valid    = 1'b1;
              res.done_status   = STATUS_TIMEOUT;
            end else begin
              wait_counter_next = wait_inc[TMO_W-1:0];
            end
          end else if (phase == PH_WAIT_TX) begin
            wait_counter_next = '0;
            phase_next        = PH_WAIT_RX;
          end else begin
            wait_counter_next = '0;
            if (receive_present) begin
              res.store_valid = 1'b1;
              res.store_data  = item.receive_byte;
            end
            current_index_next = index_inc[BYTE_W-1:0];
            phase_next = (index_inc >= {1'b0, total_bytes}) ? PH_CS_HIGH : PH_TRANSFER;
          end
        end
        PH_CS_HIGH: begin
          phase_next = PH_STOP;
        end
        PH_STOP: begin
          res.done_valid  = 1'b1;
          res.done_status = STATUS_OK;
          phase_next      = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    res.select_active = (phase_next == PH_TRANSFER) || (phase_next == PH_WAIT_TX) ||
                        (phase_next == PH_WAIT_RX) || (phase_next == PH_CS_HIGH);
    res.select_number = select_reg_next;
    res.busy_res      = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      select_reg       <= '0;
      total_bytes      <= '0;
      current_index    <= '0;
      wait_counter     <= '0;
      transmit_present <= 1'b0;
      receive_present  <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      select_reg       <= select_reg_next;
      total_bytes      <= total_bytes_next;
      current_index    <= current_index_next;
      wait_counter     <= wait_counter_next;
      transmit_present <= transmit_present_next;
      receive_present  <= receive_present_next;
    end
  end

  // counter only runs inside the two wait phases
  a_wait_idle: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_WAIT_TX && phase != PH_WAIT_RX) |-> wait_counter == '0)
    else $error("wait counter nonzero outside wait phases");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (step && res.done_valid) |=> phase == PH_IDLE)
    else $error("completion without return to idle");

  a_send_phase: assert property (@(posedge clk) disable iff (rst)
    (step && res.send_valid) |=> phase == PH_WAIT_TX)
    else $error("byte pushed without moving to transmit wait");

  a_store_rx: assert property (@(posedge clk) disable iff (rst)
    (step && res.store_valid) |-> (receive_present && phase == PH_WAIT_RX))
    else $error("store without receive buffer");

endmodule

`default_nettype wire
